@@ design/bb3_pkg.sv @@
package bb3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WID_W      = 11;
    localparam int HGT_W      = 13;
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int WIN_N      = 9;
    localparam int SUM_W      = 12;
    localparam int IDX_W      = 2;
    localparam int CFG_DATA_W = 13;

    // Division by 9 as a multiply by ceil(2^15 / 9) and a shift; exact for sums up to 2295.
    localparam int DIV9_SH = 15;
    localparam logic [SUM_W-1:0] DIV9_MUL = SUM_W'(3641);

    typedef logic [PIX_W-1:0] t_pix;

    typedef enum logic [IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } t_cfg_idx;

    function automatic logic [WID_W-1:0] eff_width(input logic [WID_W-1:0] w);
        logic [WID_W-1:0] res;
        if (w < WID_W'(2)) begin
            res = WID_W'(2);
        end else if (w > WID_W'(MAX_WIDTH)) begin
            res = WID_W'(MAX_WIDTH);
        end else begin
            res = w;
        end
        return res;
    endfunction

    function automatic logic [HGT_W-1:0] eff_height(input logic [HGT_W-1:0] h);
        logic [HGT_W-1:0] res;
        if (h < HGT_W'(2)) begin
            res = HGT_W'(2);
        end else if (h > HGT_W'(MAX_HEIGHT)) begin
            res = HGT_W'(MAX_HEIGHT);
        end else begin
            res = h;
        end
        return res;
    endfunction

    function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] s);
        logic [2*SUM_W-1:0] prod;
        prod = (2*SUM_W)'(s) * (2*SUM_W)'(DIV9_MUL);
        return prod[DIV9_SH +: CH_W];
    endfunction

endpackage

@@ design/bb3_if.sv @@
interface bb3_pix_if import bb3_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
    logic            is_flush;

    modport source (output valid, in_red, in_green, in_blue, is_flush, input ready);
    modport sink   (input valid, in_red, in_green, in_blue, is_flush, output ready);
endinterface

interface bb3_res_if import bb3_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            end_of_frame;

    modport source (output valid, out_red, out_green, out_blue, end_of_frame, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, end_of_frame, output ready);
endinterface

interface bb3_cfg_if import bb3_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [IDX_W-1:0]      index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/bb3_ram.sv @@
module bb3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/box_blur_3x3_rgb.sv @@
// Streaming 3x3 box blur over RGB pixels in raster order. One transaction is taken per
// clock; a result passes through stage 1, stage 2, stage 3 and the output register, and
// the input stalls only while the output register is full and not taken. The rate is set
// by the two line stores, each a single RAM with one read and one write per cycle: a pixel
// reads its column in the accept cycle and writes it back as it leaves stage 1, with
// forwarding when the following pixel hits the same column. frame_width and frame_height
// are written over the configuration channel while the stream is idle; widths clamp to
// 2..1024 and heights to 2..4096. After the last pixel of a frame, send frame_width+1
// flush transactions; the final one returns the bottom right pixel with end_of_frame set,
// and the next frame may follow at once. The line stores need no clearing after reset.
module box_blur_3x3_rgb import bb3_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bb3_pix_if.sink   i_pix,
    bb3_res_if.source o_res,
    bb3_cfg_if.sink   i_cfg
);

    // Configuration and position.
    logic [WID_W-1:0] r_fw;
    logic [HGT_W-1:0] r_fh;
    logic [COL_W-1:0] r_col;
    logic [HGT_W-1:0] r_row;

    // Accept stage.
    logic [WID_W-1:0] w_w;
    logic [HGT_W-1:0] w_h;
    logic [COL_W-1:0] w_c;
    logic [WID_W-1:0] w_c_inc;
    logic             w_flush;
    t_pix             w_pix;
    logic             w_last;
    logic             w_emit;
    logic             w_upz;
    logic             w_loz;
    logic             w_accept;
    logic             w_hit;
    logic [COL_W-1:0] n_col;
    logic [HGT_W-1:0] n_row;

    // Flow control.
    logic w_free1;
    logic w_free2;
    logic w_free3;
    logic w_free_o;
    logic w_mv12;

    // Stage 1: line store read data available.
    logic             r_s1_v;
    logic [COL_W-1:0] r_s1_c;
    t_pix             r_s1_pix;
    logic             r_s1_upz;
    logic             r_s1_loz;
    logic             r_s1_emit;
    logic             r_s1_last;
    logic             r_s1_c0;
    logic             r_s1_c1;
    logic             r_s1_fwd;
    t_pix             r_s1_fup;
    t_pix             r_s1_flo;
    t_pix             w_ram_up;
    t_pix             w_ram_lo;
    t_pix             w_up_m;
    t_pix             w_lo_m;

    // Window, column 0 oldest, entry index column * 3 + row.
    t_pix r_win [WIN_N];

    // Stage 2: masked window.
    logic r_s2_v;
    t_pix r_s2_px [WIN_N];
    logic r_s2_emit;
    logic r_s2_last;
    logic [SUM_W-1:0] w_sum [3];

    // Stage 3: channel sums.
    logic             r_s3_v;
    logic [SUM_W-1:0] r_s3_sum [3];
    logic             r_s3_last;

    // Output register.
    logic            r_ov;
    logic [CH_W-1:0] r_o_red;
    logic [CH_W-1:0] r_o_green;
    logic [CH_W-1:0] r_o_blue;
    logic            r_o_eof;

    assign w_free_o = !r_ov || o_res.ready;
    assign w_free3  = !r_s3_v || w_free_o;
    assign w_free2  = !r_s2_v || w_free3;
    assign w_free1  = !r_s1_v || w_free2;
    assign w_mv12   = r_s1_v && w_free2;

    assign i_pix.ready = w_free1;
    assign w_accept    = i_pix.valid && w_free1;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        w_w = eff_width(r_fw);
        w_h = eff_height(r_fh);
        if ({1'b0, r_col} >= w_w) begin
            w_c = COL_W'(w_w - WID_W'(1));
        end else begin
            w_c = r_col;
        end
        w_flush = i_pix.is_flush || (r_row >= w_h);
        w_pix   = w_flush ? '0 : {i_pix.in_red, i_pix.in_green, i_pix.in_blue};
        w_last  = ({1'b0, r_row} >= ({1'b0, w_h} + (HGT_W+1)'(1)));
        w_emit  = (r_row >= HGT_W'(2)) || ((r_row == HGT_W'(1)) && (w_c != '0));
        w_upz   = r_row < HGT_W'(2);
        w_loz   = (r_row == '0) || w_last;
        w_c_inc = {1'b0, w_c} + WID_W'(1);
        // The pixel in stage 1 writes back in this cycle; a read of the same column
        // would see the old entry, so its new contents are passed along instead.
        w_hit   = r_s1_v && (r_s1_c == w_c);
        if (w_last) begin
            n_col = '0;
            n_row = '0;
        end else if (w_c_inc >= w_w) begin
            n_col = '0;
            n_row = r_row + HGT_W'(1);
        end else begin
            n_col = w_c_inc[COL_W-1:0];
            n_row = r_row;
        end
    end

    bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (w_mv12),
        .i_waddr (r_s1_c),
        .i_wdata (w_lo_m),
        .i_re    (w_accept),
        .i_raddr (w_c),
        .o_rdata (w_ram_up)
    );

    bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
        .i_clk   (i_clk),
        .i_we    (w_mv12),
        .i_waddr (r_s1_c),
        .i_wdata (r_s1_pix),
        .i_re    (w_accept),
        .i_raddr (w_c),
        .o_rdata (w_ram_lo)
    );

    always_comb begin
        w_up_m = r_s1_upz ? '0 : (r_s1_fwd ? r_s1_fup : w_ram_up);
        w_lo_m = r_s1_loz ? '0 : (r_s1_fwd ? r_s1_flo : w_ram_lo);
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sum[k] = '0;
            for (int i = 0; i < WIN_N; i++) begin
                w_sum[k] = w_sum[k] + SUM_W'(r_s2_px[i][CH_W*k +: CH_W]);
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw     <= WID_W'(640);
            r_fh     <= HGT_W'(480);
            r_col    <= '0;
            r_row    <= '0;
            r_s1_v   <= 1'b0;
            r_s1_fwd <= 1'b0;
            r_s2_v   <= 1'b0;
            r_s3_v   <= 1'b0;
            r_ov     <= 1'b0;
            for (int i = 0; i < WIN_N; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                unique case (t_cfg_idx'(i_cfg.index))
                    CFG_FRAME_WIDTH:  r_fw <= i_cfg.data[WID_W-1:0];
                    CFG_FRAME_HEIGHT: r_fh <= i_cfg.data[HGT_W-1:0];
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (w_free1) begin
                r_s1_v   <= w_accept;
                r_s1_fwd <= w_accept && w_hit;
            end
            if (w_mv12) begin
                for (int i = 0; i < 6; i++) begin
                    r_win[i] <= r_win[i+3];
                end
                r_win[6] <= w_up_m;
                r_win[7] <= w_lo_m;
                r_win[8] <= r_s1_pix;
            end
            if (w_free2) begin
                r_s2_v <= r_s1_v;
            end
            if (w_free3) begin
                r_s3_v <= r_s2_v && r_s2_emit;
            end
            if (w_free_o) begin
                r_ov <= r_s3_v;
            end
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_c    <= w_c;
            r_s1_pix  <= w_pix;
            r_s1_upz  <= w_upz;
            r_s1_loz  <= w_loz;
            r_s1_emit <= w_emit;
            r_s1_last <= w_last;
            r_s1_c0   <= (w_c == '0);
            r_s1_c1   <= (w_c == COL_W'(1));
            r_s1_fup  <= w_lo_m;
            r_s1_flo  <= r_s1_pix;
        end
        if (w_mv12) begin
            // Window after the shift; the oldest column drops out at the second column of
            // a row and the newest one at the first.
            for (int i = 0; i < 3; i++) begin
                r_s2_px[i]   <= r_s1_c1 ? '0 : r_win[i+3];
                r_s2_px[i+3] <= r_win[i+6];
            end
            r_s2_px[6] <= r_s1_c0 ? '0 : w_up_m;
            r_s2_px[7] <= r_s1_c0 ? '0 : w_lo_m;
            r_s2_px[8] <= r_s1_c0 ? '0 : r_s1_pix;
            r_s2_emit  <= r_s1_emit;
            r_s2_last  <= r_s1_last;
        end
        if (w_free3 && r_s2_v) begin
            for (int k = 0; k < 3; k++) begin
                r_s3_sum[k] <= w_sum[k];
            end
            r_s3_last <= r_s2_last;
        end
        if (w_free_o && r_s3_v) begin
            r_o_red   <= div9(r_s3_sum[2]);
            r_o_green <= div9(r_s3_sum[1]);
            r_o_blue  <= div9(r_s3_sum[0]);
            r_o_eof   <= r_s3_last;
        end
    end

    assign o_res.valid        = r_ov;
    assign o_res.out_red      = r_o_red;
    assign o_res.out_green    = r_o_green;
    assign o_res.out_blue     = r_o_blue;
    assign o_res.end_of_frame = r_o_eof;

    // The frame's closing transaction returns the position to the origin.
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_last) |=> (r_col == '0 && r_row == '0))
        else $error("position not at origin after end of frame");

    // Forwarded line data only comes from a pixel that was in stage 1 at the read.
    a_fwd_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && r_s1_fwd) |-> $past(r_s1_v))
        else $error("forwarding without a pixel in write-back");

    // A blocked stage 1 keeps its pixel and column until it can write back.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !w_free2) |=> (r_s1_v && $stable(r_s1_c)))
        else $error("stage 1 lost its pixel while blocked");

endmodule
